// File: hdl/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

  // Working word: signed Q4.28, the same format as the coordinate registers.
  localparam int FRAC_BITS = 28;
  localparam int WORD_W    = FRAC_BITS + 4;

  localparam int PAL_DEPTH = 1024;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int ITER_W    = 10;
  localparam int LIMIT_W   = 11;
  localparam int HEIGHT_W  = 13;
  localparam int STEP_W    = 29;
  localparam int PIX_W     = 12;
  localparam int CH_W      = 8;
  localparam int MAX_CH    = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd5;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Escape threshold 4.0 in the 33-bit sum of the two squares.
  localparam logic [WORD_W:0] ESCAPE_LIM = (WORD_W+1)'(4) << FRAC_BITS;

  localparam logic [LIMIT_W-1:0] LIMIT_CAP = 11'd1024;

  typedef struct packed {
    logic capture;    // pixel item accepted
    logic pal_wr;     // palette load accepted
    logic coord_mul;  // index times step
    logic coord_sum;  // base plus offset, clear z
    logic iter_mul;   // x*x, y*y, x*y
    logic iter_sat;   // scale and saturate products
    logic iter_upd;   // escape test and z update
    logic pal_rd;     // palette read at the count
    logic out_load;   // load the result register
  } mbe_cmd_t;

  typedef struct packed {
    logic iter_done;
  } mbe_sts_t;

  // Saturate a signed value to the working word.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[63:WORD_W-1];
    hi_zeros = ~|v[63:WORD_W-1];
    if (hi_ones || hi_zeros) begin
      sat_word = v[WORD_W-1:0];
    end else if (v[63]) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/mbe_ctrl.sv
`default_nettype none

module mbe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_action,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  mbe_pkg::mbe_sts_t     sts,
  output mbe_pkg::mbe_cmd_t     cmd
);

  import mbe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMUL = 3'd1;
  localparam logic [2:0] ST_CSUM = 3'd2;
  localparam logic [2:0] ST_IMUL = 3'd3;
  localparam logic [2:0] ST_ISAT = 3'd4;
  localparam logic [2:0] ST_IUPD = 3'd5;
  localparam logic [2:0] ST_PRD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == ST_IDLE) && in_valid && (in_action == ACT_PIXEL);
    cmd.pal_wr    = (state_r == ST_IDLE) && in_valid && (in_action == ACT_LOAD);
    cmd.coord_mul = (state_r == ST_CMUL);
    cmd.coord_sum = (state_r == ST_CSUM);
    cmd.iter_mul  = (state_r == ST_IMUL);
    cmd.iter_sat  = (state_r == ST_ISAT);
    cmd.iter_upd  = (state_r == ST_IUPD);
    cmd.pal_rd    = (state_r == ST_PRD);
    cmd.out_load  = (state_r == ST_OUT) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.capture) begin
        state_nxt = ST_CMUL;
      end
      ST_CMUL: state_nxt = ST_CSUM;
      ST_CSUM: state_nxt = ST_IMUL;
      ST_IMUL: state_nxt = ST_ISAT;
      ST_ISAT: state_nxt = ST_IUPD;
      ST_IUPD: state_nxt = sts.iter_done ? ST_PRD : ST_IMUL;
      ST_PRD:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A new result is only loaded once the previous one has gone.
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mbe_dpath.sv
`default_nettype none

module mbe_dpath #(
  parameter int CHANNELS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [mbe_pkg::PAL_AW-1:0]         in_palette_index,
  input  wire logic [mbe_pkg::CH_W-1:0]           in_load_chan0,
  input  wire logic [mbe_pkg::CH_W-1:0]           in_load_chan1,
  input  wire logic [mbe_pkg::CH_W-1:0]           in_load_chan2,
  input  wire logic [mbe_pkg::CH_W-1:0]           in_load_chan3,
  input  wire logic [mbe_pkg::PIX_W-1:0]          in_pixel_col,
  input  wire logic [mbe_pkg::PIX_W-1:0]          in_pixel_row,
  input  mbe_pkg::mbe_cmd_t                       cmd,
  output mbe_pkg::mbe_sts_t                       sts,
  output logic [mbe_pkg::PIX_W-1:0]               out_row,
  output logic [mbe_pkg::PIX_W-1:0]               out_col,
  output logic [mbe_pkg::ITER_W-1:0]              out_iteration_count,
  output logic [mbe_pkg::CH_W-1:0]                out_color_chan0,
  output logic [mbe_pkg::CH_W-1:0]                out_color_chan1,
  output logic [mbe_pkg::CH_W-1:0]                out_color_chan2,
  output logic [mbe_pkg::CH_W-1:0]                out_color_chan3
);

  import mbe_pkg::*;

  // Channels above the fourth are never stored.
  localparam int STORED_CH = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int PAL_W     = CH_W * STORED_CH;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int OFS_W     = PIX_W + STEP_W;
  localparam int CSUM_W    = OFS_W + 2;

  // Configuration
  logic signed [WORD_W-1:0]   x_min_r;
  logic [STEP_W-1:0]          x_step_r;
  logic signed [WORD_W-1:0]   y_min_r;
  logic [STEP_W-1:0]          y_step_r;
  logic [LIMIT_W-1:0]         limit_r;
  logic [HEIGHT_W-1:0]        height_r;

  // Pixel state
  logic [PIX_W-1:0]           col_r;
  logic [PIX_W-1:0]           row_r;
  logic [ITER_W-1:0]          stop_r;
  logic [ITER_W-1:0]          stop_nxt;
  logic [OFS_W-1:0]           xofs_r;
  logic [OFS_W-1:0]           yofs_r;
  logic signed [WORD_W-1:0]   cx_r;
  logic signed [WORD_W-1:0]   cy_r;
  logic signed [WORD_W-1:0]   x_r;
  logic signed [WORD_W-1:0]   y_r;
  logic signed [PROD_W-1:0]   pxx_r;
  logic signed [PROD_W-1:0]   pyy_r;
  logic signed [PROD_W-1:0]   pxy_r;
  logic signed [WORD_W-1:0]   x2_r;
  logic signed [WORD_W-1:0]   y2_r;
  logic signed [WORD_W-1:0]   xy_r;
  logic [ITER_W-1:0]          iter_r;

  logic signed [CSUM_W-1:0]   cx_sum;
  logic signed [CSUM_W-1:0]   cy_sum;
  logic [WORD_W:0]            mag_sum;
  logic                       escape;
  logic signed [WORD_W:0]     diff_sq;
  logic signed [WORD_W:0]     x_sum;
  logic signed [WORD_W:0]     y_sum;
  logic signed [WORD_W-1:0]   x_nxt;
  logic signed [WORD_W-1:0]   y_nxt;

  // Palette
  logic [PAL_W-1:0]           pal_mem [PAL_DEPTH];
  logic [PAL_W-1:0]           pal_rd_r;
  logic [4*CH_W-1:0]          load_word;
  logic [4*CH_W-1:0]          color_word;

  // Result register
  logic [PIX_W-1:0]           out_row_r;
  logic [PIX_W-1:0]           out_col_r;
  logic [ITER_W-1:0]          out_iter_r;
  logic [4*CH_W-1:0]          out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= -WORD_W'(536870912);
      x_step_r <= STEP_W'(1048576);
      y_min_r  <= -WORD_W'(536870912);
      y_step_r <= STEP_W'(1048576);
      limit_r  <= LIMIT_W'(256);
      height_r <= HEIGHT_W'(512);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_X_MIN:      x_min_r  <= cfg_wdata[WORD_W-1:0];
        CFG_X_STEP:     x_step_r <= cfg_wdata[STEP_W-1:0];
        CFG_Y_MIN:      y_min_r  <= cfg_wdata[WORD_W-1:0];
        CFG_Y_STEP:     y_step_r <= cfg_wdata[STEP_W-1:0];
        CFG_ITER_LIMIT: limit_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_HEIGHT:     height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Last iteration index: limits of zero and one both run no iteration.
  always_comb begin
    priority if (limit_r > LIMIT_CAP) begin
      stop_nxt = {ITER_W{1'b1}};
    end else if (limit_r == '0) begin
      stop_nxt = '0;
    end else begin
      stop_nxt = ITER_W'(limit_r - LIMIT_W'(1));
    end
  end

  assign cx_sum = CSUM_W'(x_min_r) + $signed({2'b00, xofs_r});
  assign cy_sum = CSUM_W'(y_min_r) + $signed({2'b00, yofs_r});

  // Both squares are never negative, so the escape sum is taken unsigned.
  assign mag_sum = {1'b0, x2_r} + {1'b0, y2_r};
  assign escape  = mag_sum > ESCAPE_LIM;

  assign diff_sq = (WORD_W+1)'(x2_r) - (WORD_W+1)'(y2_r);
  assign x_sum   = (WORD_W+1)'(sat_word(PROD_W'(diff_sq))) + (WORD_W+1)'(cx_r);
  assign y_sum   = (WORD_W+1)'(xy_r) + (WORD_W+1)'(cy_r);
  assign x_nxt   = sat_word(PROD_W'(x_sum));
  assign y_nxt   = sat_word(PROD_W'(y_sum));

  assign sts.iter_done = (iter_r >= stop_r) || escape;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r  <= in_pixel_col;
      row_r  <= in_pixel_row;
      stop_r <= stop_nxt;
    end
    if (cmd.coord_mul) begin
      xofs_r <= OFS_W'(col_r) * OFS_W'(x_step_r);
      yofs_r <= OFS_W'(row_r) * OFS_W'(y_step_r);
    end
    if (cmd.coord_sum) begin
      cx_r   <= sat_word(PROD_W'(cx_sum));
      cy_r   <= sat_word(PROD_W'(cy_sum));
      x_r    <= '0;
      y_r    <= '0;
      iter_r <= '0;
    end
    if (cmd.iter_mul) begin
      pxx_r <= PROD_W'(x_r) * PROD_W'(x_r);
      pyy_r <= PROD_W'(y_r) * PROD_W'(y_r);
      pxy_r <= PROD_W'(x_r) * PROD_W'(y_r);
    end
    // Arithmetic shifts floor towards minus infinity; the cross term carries 2*x*y.
    if (cmd.iter_sat) begin
      x2_r <= sat_word(pxx_r >>> FRAC_BITS);
      y2_r <= sat_word(pyy_r >>> FRAC_BITS);
      xy_r <= sat_word(pxy_r >>> (FRAC_BITS - 1));
    end
    if (cmd.iter_upd && !sts.iter_done) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      iter_r <= iter_r + ITER_W'(1);
    end
  end

  assign load_word = {in_load_chan3, in_load_chan2, in_load_chan1, in_load_chan0};

  always_ff @(posedge clk) begin
    if (cmd.pal_wr) begin
      pal_mem[in_palette_index] <= load_word[PAL_W-1:0];
    end
    if (cmd.pal_rd) begin
      pal_rd_r <= pal_mem[iter_r[PAL_AW-1:0]];
    end
  end

  assign color_word = (4*CH_W)'(pal_rd_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r   <= PIX_W'(height_r - HEIGHT_W'(row_r) - HEIGHT_W'(1));
      out_col_r   <= col_r;
      out_iter_r  <= iter_r;
      out_color_r <= color_word;
    end
  end

  assign out_row             = out_row_r;
  assign out_col             = out_col_r;
  assign out_iteration_count = out_iter_r;
  assign out_color_chan0     = out_color_r[0*CH_W +: CH_W];
  assign out_color_chan1     = out_color_r[1*CH_W +: CH_W];
  assign out_color_chan2     = out_color_r[2*CH_W +: CH_W];
  assign out_color_chan3     = out_color_r[3*CH_W +: CH_W];

endmodule

`default_nettype wire

// File: hdl/mandelbrot_escape_time_pixel_core.sv
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_action, in_palette_index, in_load_chan0..3,
//                                  in_pixel_col, in_pixel_row
// out       out_valid / out_stall  out_row, out_col, out_iteration_count,
//                                  out_color_chan0..3
// cfg       cfg_wr_en              cfg_index, cfg_wdata
//
// A palette load gives no result. For a pixel, each iteration passes once through
// the squaring multipliers, the scaling stage and the update.
// Reset is synchronous and restores the configuration and control registers; the
// palette is not cleared.
// A result waits in the output register while the next item is accepted; the core
// holds in_stall only while a pixel is being computed or its result cannot be placed.
`default_nettype none

module mandelbrot_escape_time_pixel_core #(
  parameter int CHANNELS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_action,
  input  wire logic [mbe_pkg::PAL_AW-1:0]        in_palette_index,
  input  wire logic [mbe_pkg::CH_W-1:0]          in_load_chan0,
  input  wire logic [mbe_pkg::CH_W-1:0]          in_load_chan1,
  input  wire logic [mbe_pkg::CH_W-1:0]          in_load_chan2,
  input  wire logic [mbe_pkg::CH_W-1:0]          in_load_chan3,
  input  wire logic [mbe_pkg::PIX_W-1:0]         in_pixel_col,
  input  wire logic [mbe_pkg::PIX_W-1:0]         in_pixel_row,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mbe_pkg::PIX_W-1:0]              out_row,
  output logic [mbe_pkg::PIX_W-1:0]              out_col,
  output logic [mbe_pkg::ITER_W-1:0]             out_iteration_count,
  output logic [mbe_pkg::CH_W-1:0]               out_color_chan0,
  output logic [mbe_pkg::CH_W-1:0]               out_color_chan1,
  output logic [mbe_pkg::CH_W-1:0]               out_color_chan2,
  output logic [mbe_pkg::CH_W-1:0]               out_color_chan3
);

  import mbe_pkg::*;

  mbe_cmd_t cmd;
  mbe_sts_t sts;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbe_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_palette_index    (in_palette_index),
    .in_load_chan0       (in_load_chan0),
    .in_load_chan1       (in_load_chan1),
    .in_load_chan2       (in_load_chan2),
    .in_load_chan3       (in_load_chan3),
    .in_pixel_col        (in_pixel_col),
    .in_pixel_row        (in_pixel_row),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_row             (out_row),
    .out_col             (out_col),
    .out_iteration_count (out_iteration_count),
    .out_color_chan0     (out_color_chan0),
    .out_color_chan1     (out_color_chan1),
    .out_color_chan2     (out_color_chan2),
    .out_color_chan3     (out_color_chan3)
  );

`ifndef SYNTHESIS
  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register loaded while a result still waits");

  // After a pixel is accepted the core is busy with it.
  a_busy_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action == ACT_PIXEL) |=> in_stall)
    else $error("pixel accepted but core not busy");

  // The sequencer issues at most one datapath step at a time.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire
